[rtl/u8d_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
// Used by u8d_decode, u8d_res_fifo and utf8_stream_decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned CntW = 3;

  localparam logic [7:0] AsciiMask   = 8'h80;
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContTag     = 8'h80;
  localparam logic [7:0] Lead2Mask   = 8'hE0;
  localparam logic [7:0] Lead2Tag    = 8'hC0;
  localparam logic [7:0] Lead3Mask   = 8'hF0;
  localparam logic [7:0] Lead3Tag    = 8'hE0;
  localparam logic [7:0] Lead4Mask   = 8'hF8;
  localparam logic [7:0] Lead4Tag    = 8'hF0;
  localparam logic [7:0] Pay2Mask    = 8'h1F;
  localparam logic [7:0] Pay3Mask    = 8'h0F;
  localparam logic [7:0] Pay4Mask    = 8'h07;
  localparam logic [7:0] ContPayMask = 8'h3F;
  // Two-byte leads whose payload is below this value are overlong.
  localparam logic [7:0] Lead2MinPay = 8'h02;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [CntW-1:0] byte_count;
    logic            is_error;
    logic            last_of_run;
  } result_t;

  typedef struct packed {
    logic [CpW-1:0]  partial_value;
    logic [1:0]      bytes_remaining;
    logic [CntW-1:0] bytes_taken;
  } dec_state_t;

  typedef struct packed {
    result_t    res0;
    result_t    res1;
    logic [1:0] num;
  } dec_out_t;

endpackage

`default_nettype wire

[rtl/u8d_decode.sv]
// Combinational decode of one byte against the open-sequence state.
// Produces up to two results and the next state. Depends on u8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8d_decode (
  input  wire logic [7:0]         data_byte_i,
  input  wire u8d_pkg::dec_state_t state_i,
  output u8d_pkg::dec_state_t     state_o,
  output u8d_pkg::dec_out_t       out_o
);
  import u8d_pkg::*;

  logic       idle_emit;
  result_t    idle_res;
  dec_state_t idle_st;
  logic [1:0] rem_dec;
  logic [2:0] taken_inc;
  logic [CpW-1:0] cont_val;
  logic       is_cont;

  // Decode as if no sequence were open. The idle state always holds zeros.
  always_comb begin
    idle_emit   = 1'b1;
    idle_res    = '0;
    idle_res.byte_count = 3'd1;
    idle_res.is_error   = 1'b1;
    idle_st     = '0;
    if ((data_byte_i & AsciiMask) == 8'h00) begin
      idle_res.code_point = {13'b0, data_byte_i};
      idle_res.is_error   = 1'b0;
    end else if ((data_byte_i & Lead2Mask) == Lead2Tag) begin
      if ((data_byte_i & Pay2Mask) >= Lead2MinPay) begin
        idle_emit = 1'b0;
        idle_st.partial_value   = {13'b0, data_byte_i & Pay2Mask};
        idle_st.bytes_remaining = 2'd1;
        idle_st.bytes_taken     = 3'd1;
      end
    end else if ((data_byte_i & Lead3Mask) == Lead3Tag) begin
      idle_emit = 1'b0;
      idle_st.partial_value   = {13'b0, data_byte_i & Pay3Mask};
      idle_st.bytes_remaining = 2'd2;
      idle_st.bytes_taken     = 3'd1;
    end else if ((data_byte_i & Lead4Mask) == Lead4Tag) begin
      idle_emit = 1'b0;
      idle_st.partial_value   = {13'b0, data_byte_i & Pay4Mask};
      idle_st.bytes_remaining = 2'd3;
      idle_st.bytes_taken     = 3'd1;
    end
  end

  assign is_cont   = (data_byte_i & ContMask) == ContTag;
  assign rem_dec   = state_i.bytes_remaining - 2'd1;
  assign taken_inc = state_i.bytes_taken + 3'd1;
  assign cont_val  = {state_i.partial_value[CpW-7:0], data_byte_i[5:0] & ContPayMask[5:0]};

  always_comb begin
    state_o = state_i;
    out_o   = '0;
    if (state_i.bytes_remaining == 2'd0) begin
      state_o        = idle_st;
      out_o.res0     = idle_res;
      out_o.num      = {1'b0, idle_emit};
    end else if (is_cont) begin
      if (rem_dec == 2'd0) begin
        state_o                = '0;
        out_o.res0.code_point  = cont_val;
        out_o.res0.byte_count  = taken_inc;
        out_o.num              = 2'd1;
      end else begin
        state_o.partial_value   = cont_val;
        state_o.bytes_remaining = rem_dec;
        state_o.bytes_taken     = taken_inc;
      end
    end else begin
      // The open sequence is dropped, then the byte is decoded afresh.
      state_o               = idle_st;
      out_o.res0.byte_count = state_i.bytes_taken;
      out_o.res0.is_error   = 1'b1;
      out_o.res1            = idle_res;
      out_o.num             = idle_emit ? 2'd2 : 2'd1;
    end
    if (out_o.num == 2'd1) begin
      out_o.res0.last_of_run = 1'b1;
    end else if (out_o.num == 2'd2) begin
      out_o.res1.last_of_run = 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/u8d_res_fifo.sv]
// Result queue: takes up to two results per cycle, delivers one per cycle while ready_i is high.
// Depends on u8d_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module u8d_res_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       push_num_i,
  input  wire u8d_pkg::result_t push0_i,
  input  wire u8d_pkg::result_t push1_i,
  output logic                  room2_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output u8d_pkg::result_t      data_o
);
  import u8d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  result_t             mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, wr_ptr1, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]  count_q, count_d;
  logic                pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop      = valid_o && ready_i;
  assign valid_o  = count_q != '0;
  assign data_o   = mem_q[rd_ptr_q];
  assign room2_o  = count_q <= CntBits'(Depth - 2);
  assign wr_ptr1  = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_num_i == 2'd1) begin
      wr_ptr_d = wr_ptr1;
    end else if (push_num_i == 2'd2) begin
      wr_ptr_d = ptr_inc(wr_ptr1);
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntBits'(push_num_i) - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[wr_ptr1] <= push1_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntBits'(Depth))
    else $error("result queue count exceeds its depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_num_i != 2'd0) |-> room2_o)
    else $error("results pushed without room for two");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_num_i == 2'd0 && !pop) |=> count_q == $past(count_q))
    else $error("queue count moved with no push and no pop");

endmodule

`default_nettype wire

[rtl/utf8_stream_decoder.sv]
// UTF-8 stream decoder, one input word per clock, one result word per clock when neither side stalls.
// Depends on u8d_pkg, u8d_decode and u8d_res_fifo.
//
// Takes one byte per cycle while the result queue has room for two results. A
// byte is registered on acceptance and decoded from that register into a small
// result queue once the queue has room; the first result it causes reaches the
// output from the queue registers after that push. Bytes are accepted every
// cycle as long as the queue has room for two results; a byte that causes two
// results (a broken sequence followed by a byte that decodes on its own) takes
// two result slots at the output, so the sustained rate is one byte per cycle
// except where the output port, delivering one result per cycle when taken, falls behind.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [20:0]      code_point_o,
  output logic [2:0]       byte_count_o,
  output logic             is_error_o,
  output logic             last_of_run_o
);
  import u8d_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  dec_state_t state_q, state_d;
  dec_out_t   dec_out;
  logic       room2, adv;
  logic [1:0] push_num;
  result_t    out_res;

  assign adv        = in_valid_q && room2;
  assign in_ready_o = !in_valid_q || adv;
  assign push_num   = adv ? dec_out.num : 2'd0;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  u8d_decode u_decode (
    .data_byte_i (in_byte_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .out_o       (dec_out)
  );

  u8d_res_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_num_i (push_num),
    .push0_i    (dec_out.res0),
    .push1_i    (dec_out.res1),
    .room2_o    (room2),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (out_res)
  );

  assign code_point_o  = out_res.code_point;
  assign byte_count_o  = out_res.byte_count;
  assign is_error_o    = out_res.is_error;
  assign last_of_run_o = out_res.last_of_run;

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.bytes_remaining == 2'd0) |->
      (state_q.partial_value == '0 && state_q.bytes_taken == '0))
    else $error("idle decoder state holds leftover bits");

  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.bytes_remaining != 2'd0) |->
      ({1'b0, state_q.bytes_remaining} + state_q.bytes_taken <= 3'd4))
    else $error("open sequence longer than four bytes");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_error_o) |-> (code_point_o == '0))
    else $error("error result carries a code point");

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for utf8_stream_decoder: a byte driver, a result monitor and
// a behavioral decoder that predicts every result word. Depends on u8d_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import u8d_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseBytes  = 212;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte   = 8'h00;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [20:0] code_point;
  logic [2:0]  byte_count;
  logic        is_error;
  logic        last_of_run;

  // Bytes waiting to be driven and decoded words waiting to come out.
  logic [7:0]  pending_bytes[$];
  result_t     expected_chars[$];

  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          took_byte      = 1'b0;

  // Decoder state of the predictor.
  logic [20:0] part_val = '0;
  logic [1:0]  left_cnt = '0;
  logic [2:0]  seen_cnt = '0;

  always #2 clk = ~clk;

  utf8_stream_decoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .code_point_o (code_point),
    .byte_count_o (byte_count),
    .is_error_o   (is_error),
    .last_of_run_o(last_of_run)
  );

  // Decodes a byte as if no sequence were open; returns 1 when it yields a word.
  function automatic bit fresh_byte(input logic [7:0] b, output result_t r);
    r = '0;
    r.byte_count = 3'd1;
    if ((b & AsciiMask) == 8'h00) begin
      r.code_point = 21'(b);
      return 1'b1;
    end
    if ((b & Lead2Mask) == Lead2Tag) begin
      if ((b & Pay2Mask) < Lead2MinPay) begin
        r.is_error = 1'b1;
        return 1'b1;
      end
      part_val = 21'(b & Pay2Mask);
      left_cnt = 2'd1;
      seen_cnt = 3'd1;
      return 1'b0;
    end
    if ((b & Lead3Mask) == Lead3Tag) begin
      part_val = 21'(b & Pay3Mask);
      left_cnt = 2'd2;
      seen_cnt = 3'd1;
      return 1'b0;
    end
    if ((b & Lead4Mask) == Lead4Tag) begin
      part_val = 21'(b & Pay4Mask);
      left_cnt = 2'd3;
      seen_cnt = 3'd1;
      return 1'b0;
    end
    r.is_error = 1'b1;
    return 1'b1;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    result_t r0;
    result_t r1;
    bit      has0;
    bit      has1;
    has0 = 1'b0;
    has1 = 1'b0;
    r0   = '0;
    r1   = '0;
    if (left_cnt == 2'd0) begin
      has0 = fresh_byte(b, r0);
    end else if ((b & ContMask) == ContTag) begin
      part_val = {part_val[14:0], b[5:0]};
      left_cnt = left_cnt - 2'd1;
      seen_cnt = seen_cnt + 3'd1;
      if (left_cnt == 2'd0) begin
        r0.code_point = part_val;
        r0.byte_count = seen_cnt;
        has0 = 1'b1;
        part_val = '0;
        seen_cnt = '0;
      end
    end else begin
      // The open sequence is dropped, then the byte starts over on its own.
      r0.byte_count = seen_cnt;
      r0.is_error = 1'b1;
      has0 = 1'b1;
      part_val = '0;
      left_cnt = '0;
      seen_cnt = '0;
      has1 = fresh_byte(b, r1);
    end
    if (has1) begin
      r1.last_of_run = 1'b1;
      expected_chars.push_back(r0);
      expected_chars.push_back(r1);
    end else if (has0) begin
      r0.last_of_run = 1'b1;
      expected_chars.push_back(r0);
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_total++;
  endtask

  function automatic logic [7:0] lead_for(input int unsigned len);
    case (len)
      2: return 8'hC0 | 8'($urandom_range(2, 31));
      3: return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return ContTag | 8'($urandom_range(0, 63));
  endfunction

  task automatic queue_random(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int unsigned keep;
    logic [7:0]  b;
    start = queued_total;
    while (queued_total - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(1, 4);
        if (len == 1) begin
          queue_byte(8'($urandom_range(0, 127)));
        end else begin
          queue_byte(lead_for(len));
          repeat (len - 1) queue_byte(cont_byte());
        end
      end else if (pick < 85) begin
        // Truncated sequence cut off by a byte that is not a continuation.
        len  = $urandom_range(2, 4);
        keep = $urandom_range(0, len - 2);
        queue_byte(lead_for(len));
        repeat (keep) queue_byte(cont_byte());
        do b = 8'($urandom_range(0, 255));
        while ((b & ContMask) == ContTag);
        queue_byte(b);
      end else begin
        queue_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain_all();
    while (accepted_total != queued_total || expected_chars.size() != 0) @(posedge clk);
  endtask

  // Driver: a word stays on the port until it is taken.
  always @(negedge clk) begin
    bit present;
    if (rst_n && (!in_valid || took_byte)) begin
      took_byte = 1'b0;
      present = (pending_bytes.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
      if (present) begin
        data_byte <= pending_bytes.pop_front();
      end
      in_valid <= present;
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor, predictor and watchdog.
  always @(posedge clk) begin
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        took_byte = 1'b1;
        moved = 1'b1;
        accepted_total++;
        decode_byte(data_byte);
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected word", code_point, 0);
        end else begin
          want = expected_chars.pop_front();
          if (code_point !== want.code_point)
            report_mismatch("code_point", code_point, want.code_point);
          if (byte_count !== want.byte_count)
            report_mismatch("byte_count", byte_count, want.byte_count);
          if (is_error !== want.is_error)
            report_mismatch("is_error", is_error, want.is_error);
          if (last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", last_of_run, want.last_of_run);
        end
      end
    end
    if (moved) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: ASCII extremes, overlong and stray bytes, longest forms,
    // and sequences broken by a fresh byte.
    queue_byte(8'h00);
    queue_byte(8'h7F);
    queue_byte(8'hC0);
    queue_byte(8'hC1);
    queue_byte(8'h80);
    queue_byte(8'hFF);
    queue_byte(8'hC2); queue_byte(8'h80);
    queue_byte(8'hE0); queue_byte(8'h80); queue_byte(8'h80);
    queue_byte(8'hF7); queue_byte(8'hBF); queue_byte(8'hBF); queue_byte(8'hBF);
    queue_byte(8'hE1); queue_byte(8'h41);
    queue_byte(8'hF1); queue_byte(8'h80); queue_byte(8'h80); queue_byte(8'hC0);
    queue_byte(8'hC5); queue_byte(8'hE4); queue_byte(8'hB8); queue_byte(8'hAD);
    drain_all();

    queue_random(PhaseBytes);
    drain_all();

    send_idle_pct  = 51;
    recv_stall_pct = 0;
    queue_random(PhaseBytes);
    drain_all();

    send_idle_pct  = 0;
    recv_stall_pct = 51;
    queue_random(PhaseBytes);
    drain_all();

    send_idle_pct  = 15;
    recv_stall_pct = 15;
    queue_random(PhaseBytes);
    drain_all();

    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
